[hdl/hesd_pkg.sv]
// Shared types and constants for the heading error servo drive.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hesd_pkg;

  // CORDIC datapath width: 256 * 17-bit offset-corrected sample plus gain growth
  localparam int CW      = 28;
  localparam int TAB_LEN = 24;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OFFSET_X  = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_CENTER    = 2'd3;

  // Reset values of the registers
  localparam logic [15:0] THRESHOLD_RST = 16'd1565;
  localparam logic [9:0]  CENTER_RST    = 10'd750;

  // Largest duty that the back end can produce (1023 + 149)
  localparam logic [10:0] DUTY_MAX = 11'd1172;

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Vector and angle handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic [15:0]          enc;
    logic                 zero;
  } hesd_vec_t;

endpackage

[hdl/hesd_front.sv]
// Front stage: hard-iron offset removal and half-plane pre-rotation.
// Depends on hesd_pkg.
`timescale 1ns / 1ps

module hesd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [15:0]              mag_x,
  input  logic [15:0]              mag_y,
  input  logic [15:0]              enc,
  input  logic [15:0]              offset_x,
  input  logic [15:0]              offset_y,
  output logic                     valid_o,
  output hesd_pkg::hesd_vec_t      vec_o
);
  import hesd_pkg::*;

  logic signed [16:0]   dx, dy;
  logic signed [CW-1:0] x0, y0;
  hesd_vec_t            vec_nxt, vec_r;
  logic                 valid_r;

  // exact 17-bit differences
  assign dx = $signed({mag_x[15], mag_x}) - $signed({offset_x[15], offset_x});
  assign dy = $signed({mag_y[15], mag_y}) - $signed({offset_y[15], offset_y});

  // (X, Y) = (256*dx, -256*dy); fold into the right half plane
  always_comb begin
    x0 = {{(CW-25){dx[16]}}, dx, 8'd0};
    y0 = -{{(CW-25){dy[16]}}, dy, 8'd0};
    vec_nxt.enc  = enc;
    vec_nxt.zero = (dx == 17'sd0) && (dy == 17'sd0);
    if (dx[16]) begin
      vec_nxt.x = -x0;
      vec_nxt.y = -y0;
      vec_nxt.z = 32'h8000_0000;
    end else begin
      vec_nxt.x = x0;
      vec_nxt.y = y0;
      vec_nxt.z = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

[hdl/hesd_cell.sv]
// One vectoring CORDIC micro-rotation, registered.
// Depends on hesd_pkg for the vector type and the atan table.
`timescale 1ns / 1ps

module hesd_cell #(
  parameter int SHIFT = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_i,
  input  hesd_pkg::hesd_vec_t      vec_i,
  output logic                     valid_o,
  output hesd_pkg::hesd_vec_t      vec_o
);
  import hesd_pkg::*;

  logic signed [CW-1:0] xs, ys;
  hesd_vec_t            vec_nxt, vec_r;
  logic                 valid_r;

  // arithmetic shift rounds toward minus infinity
  assign xs = vec_i.x >>> SHIFT;
  assign ys = vec_i.y >>> SHIFT;

  // drive Y towards zero, accumulate the angle turned
  always_comb begin
    vec_nxt = vec_i;
    if (!vec_i.y[CW-1]) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + ATAN_TAB[SHIFT];
    end else begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

[hdl/hesd_back.sv]
// Back end: heading rounding, wrapped error, proportional duty, output register.
// Depends on hesd_pkg.
`timescale 1ns / 1ps

module hesd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_i,
  input  hesd_pkg::hesd_vec_t      vec_i,
  input  logic [15:0]              threshold,
  input  logic [9:0]               center,
  output logic                     out_valid,
  output logic [10:0]              out_duty,
  output logic [15:0]              out_heading,
  output logic [15:0]              out_error
);
  import hesd_pkg::*;

  logic [31:0]        z_rnd;
  logic [15:0]        head_nxt, err_nxt;
  logic signed [25:0] prod;
  logic signed [25:0] prod_adj;
  logic signed [8:0]  term_nxt;
  logic               below_nxt;

  logic               fin_valid_r;
  logic [15:0]        head_r, err_r;
  logic signed [8:0]  term_r;
  logic               below_r;

  logic signed [11:0] sum;
  logic [10:0]        duty_nxt;
  logic               out_valid_r;
  logic [10:0]        duty_r;
  logic [15:0]        out_head_r, out_err_r;

  // heading = nearest 2^-16 turn; zero vector reads as 0
  assign z_rnd    = vec_i.z + 32'h0000_8000;
  assign head_nxt = vec_i.zero ? 16'd0 : z_rnd[31:16];
  assign err_nxt  = head_nxt - vec_i.enc;

  // trunc(err*300/65536) toward zero
  assign prod      = $signed({{10{err_nxt[15]}}, err_nxt}) * 26'sd300;
  assign prod_adj  = prod[25] ? (prod + 26'sd65535) : prod;
  assign term_nxt  = prod_adj[24:16];
  assign below_nxt = $signed(err_nxt) <= $signed(threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r  <= head_nxt;
      err_r   <= err_nxt;
      term_r  <= term_nxt;
      below_r <= below_nxt;
    end
  end

  // duty: centre plus term, clamped at zero, or centre alone
  assign sum = $signed({2'b00, center}) + $signed({{3{term_r[8]}}, term_r});
  always_comb begin
    if (!below_r) begin
      duty_nxt = {1'b0, center};
    end else if (sum[11]) begin
      duty_nxt = 11'd0;
    end else begin
      duty_nxt = sum[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_r     <= duty_nxt;
      out_head_r <= head_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty    = duty_r;
  assign out_heading = out_head_r;
  assign out_error   = out_err_r;

  // duty never leaves its range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (duty_r <= DUTY_MAX))
    else $error("duty out of range");

  // a held pipeline keeps the finishing stage
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid_r && !en) |=> (fin_valid_r && $stable(head_r) && $stable(err_r)))
    else $error("finishing stage lost while stalled");

  // a stalled result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !en) |=> out_valid_r)
    else $error("result dropped while stalled");

endmodule

[hdl/heading_error_servo_drive_unit.sv]
// Path from input transfer to result valid: front stage, one cell per CORDIC
// micro-rotation (at most TAB_LEN cells), two back-end stages.
// Throughput: one item per cycle; the whole cell chain advances together and
// holds only while the output register is full and out_tready is low.
// Reset (rst_n, synchronous): clears all valid bits and loads the register
// defaults offset_x = 0, offset_y = 0, error_threshold = 1565, center_duty = 750.
`timescale 1ns / 1ps

module heading_error_servo_drive_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream, tdata: mag_x [15:0], mag_y [31:16], encoder_angle [47:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // result stream, tdata: duty [10:0], heading [26:11], angle_error [42:27], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hesd_pkg::*;

  localparam int NS = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

  logic [15:0] offset_x_r, offset_y_r, threshold_r;
  logic [9:0]  center_r;
  logic        cfg_wr;
  logic        en;

  hesd_vec_t   chain_vec [NS+1];
  logic [NS:0] chain_valid;

  logic        res_valid;
  logic [10:0] res_duty;
  logic [15:0] res_head, res_err;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r  <= 16'd0;
      offset_y_r  <= 16'd0;
      threshold_r <= THRESHOLD_RST;
      center_r    <= CENTER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_OFFSET_X:  offset_x_r  <= cfg_pwdata[15:0];
        REG_OFFSET_Y:  offset_y_r  <= cfg_pwdata[15:0];
        REG_THRESHOLD: threshold_r <= cfg_pwdata[15:0];
        REG_CENTER:    center_r    <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_OFFSET_X:  cfg_prdata = {16'd0, offset_x_r};
      REG_OFFSET_Y:  cfg_prdata = {16'd0, offset_y_r};
      REG_THRESHOLD: cfg_prdata = {16'd0, threshold_r};
      REG_CENTER:    cfg_prdata = {22'd0, center_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // chain advances unless a finished result is waiting and out_tready is low
  assign en        = !res_valid || out_tready;
  assign in_tready = en;

  hesd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .mag_x    (in_tdata[15:0]),
    .mag_y    (in_tdata[31:16]),
    .enc      (in_tdata[47:32]),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .valid_o  (chain_valid[0]),
    .vec_o    (chain_vec[0])
  );

  // row of CORDIC cells
  for (genvar i = 0; i < NS; i++) begin : g_cell
    hesd_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_valid[i]),
      .vec_i   (chain_vec[i]),
      .valid_o (chain_valid[i+1]),
      .vec_o   (chain_vec[i+1])
    );
  end

  hesd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .valid_i     (chain_valid[NS]),
    .vec_i       (chain_vec[NS]),
    .threshold   (threshold_r),
    .center      (center_r),
    .out_valid   (res_valid),
    .out_duty    (res_duty),
    .out_heading (res_head),
    .out_error   (res_err)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {5'd0, res_err, res_head, res_duty};

endmodule
